// ----- design/gsr_pkg.sv -----
// Shared constants and types of the gated sample recorder.
// Holds field widths, reset values and configuration register indexes.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package gsr_pkg;

  // Field widths of the configuration registers and the transactions.
  localparam int unsigned POS_W    = 21;
  localparam int unsigned ADDR_W   = 20;
  localparam int unsigned SAMPLE_W = 32;
  localparam int unsigned QUOT_W   = 16;
  localparam int unsigned FRAC_W   = QUOT_W + 1;
  localparam int unsigned CFG_IDX_W = 3;

  // Default depth of the target buffer.
  localparam int unsigned GSR_BUFFER_DEPTH = 1048576;

  typedef logic [POS_W-1:0]     pos_t;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
  typedef logic [FRAC_W-1:0]    frac_t;

  // Configuration register indexes.
  localparam cfg_idx_t CFG_START_INDEX     = 3'd0;
  localparam cfg_idx_t CFG_END_INDEX       = 3'd1;
  localparam cfg_idx_t CFG_BUFFER_LENGTH   = 3'd2;
  localparam cfg_idx_t CFG_LOOP_ENABLE     = 3'd3;
  localparam cfg_idx_t CFG_CONTINUE_ENABLE = 3'd4;
  localparam cfg_idx_t CFG_BUFFER_READY    = 3'd5;

  // Reset values of the configuration registers.
  localparam pos_t RST_START_INDEX   = 21'd0;
  localparam pos_t RST_END_INDEX     = 21'd1048576;
  localparam pos_t RST_BUFFER_LENGTH = 21'd1048576;

  // Progress value that marks a finished run.
  localparam frac_t FRAC_DONE = frac_t'(1 << QUOT_W);

endpackage : gsr_pkg

`default_nettype wire

// ----- design/gated_sample_recorder_core.sv -----
// Write head of a gated audio sample recorder with a bit-serial progress divider.
// Depends on gsr_pkg for widths, reset values and register indexes.
`timescale 1ns / 1ps
`default_nettype none

// Each input transaction carries a gate level and one sample word and yields
// exactly one output transaction: a buffer write request (enable, address,
// data) and the Q16 progress through the record range, where 65536 means the
// run has finished. A rising gate edge arms a run, a falling edge stops it.
// Transactions are processed one at a time by a small sequencer. A transaction
// that writes a sample steps through S_EDGE, S_FRESH, S_HEAD, S_SUB, S_DIV and
// S_DONE; the restoring divider in S_DIV yields the 16 fraction bits one per
// cycle. One that writes nothing skips S_SUB and S_DIV, and S_HEAD unless it
// ends a run. A finished result waits in an output register, so the next input
// transaction is taken while the result is still pending downstream. The user
// must write configuration only while the block is idle; it is not enforced.
module gated_sample_recorder_core
  import gsr_pkg::*;
#(
  parameter int unsigned BUFFER_DEPTH = GSR_BUFFER_DEPTH
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  // Configuration write port.
  input  wire logic                cfg_wr_en,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [POS_W-1:0]    cfg_wdata,
  // Input channel.
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire logic                in_gate,
  input  wire logic [SAMPLE_W-1:0] in_sample_word,
  // Output channel.
  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic                     out_write_enable,
  output logic [ADDR_W-1:0]        out_write_address,
  output logic [SAMPLE_W-1:0]      out_write_data,
  output logic [FRAC_W-1:0]        out_sync_fraction
);

  // Largest effective length, limited to what the position registers hold.
  localparam pos_t DEPTH_CLAMP = (BUFFER_DEPTH > ((1 << POS_W) - 1)) ?
                                 pos_t'((1 << POS_W) - 1) : pos_t'(BUFFER_DEPTH);
  localparam pos_t LEN_MIN = pos_t'(2);
  localparam int unsigned CNT_W = $clog2(QUOT_W);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(QUOT_W - 1);

  // Sequencer state codes.
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_EDGE  = 3'd1;
  localparam logic [2:0] S_FRESH = 3'd2;
  localparam logic [2:0] S_HEAD  = 3'd3;
  localparam logic [2:0] S_SUB   = 3'd4;
  localparam logic [2:0] S_DIV   = 3'd5;
  localparam logic [2:0] S_DONE  = 3'd6;

  // Configuration registers.
  pos_t start_index_r, end_index_r, buffer_length_r;
  logic loop_enable_r, continue_enable_r, buffer_ready_r;

  // Recorder state.
  logic previous_gate_r, previous_gate_nxt;
  logic running_r, running_nxt;
  logic fresh_run_r, fresh_run_nxt;
  pos_t write_position_r, write_position_nxt;
  frac_t progress_r, progress_nxt;

  // Sequencer and per-transaction working registers.
  logic [2:0]          state_r, state_nxt;
  logic                gate_r, gate_nxt;
  logic [SAMPLE_W-1:0] sample_r, sample_nxt;
  pos_t                s_r, s_nxt;
  pos_t                e_r, e_nxt;
  pos_t                head_r, head_nxt;
  pos_t                rem_r, rem_nxt;
  pos_t                range_r, range_nxt;
  logic [QUOT_W-1:0]   quot_r, quot_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic                we_r, we_nxt;

  // Output register.
  logic                out_valid_r, out_valid_nxt;
  logic                out_we_r, out_we_nxt;
  logic [ADDR_W-1:0]   out_addr_r, out_addr_nxt;
  logic [SAMPLE_W-1:0] out_data_r, out_data_nxt;
  frac_t               out_frac_r, out_frac_nxt;

  // Combinational helpers.
  pos_t                len;
  logic                active;
  logic [POS_W:0]      rem_shift;
  logic [POS_W+1:0]    trial;
  logic                fit;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_index_r     <= RST_START_INDEX;
      end_index_r       <= RST_END_INDEX;
      buffer_length_r   <= RST_BUFFER_LENGTH;
      loop_enable_r     <= 1'b0;
      continue_enable_r <= 1'b0;
      buffer_ready_r    <= 1'b1;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_START_INDEX:     start_index_r     <= cfg_wdata;
        CFG_END_INDEX:       end_index_r       <= cfg_wdata;
        CFG_BUFFER_LENGTH:   buffer_length_r   <= cfg_wdata;
        CFG_LOOP_ENABLE:     loop_enable_r     <= cfg_wdata[0];
        CFG_CONTINUE_ENABLE: continue_enable_r <= cfg_wdata[0];
        CFG_BUFFER_READY:    buffer_ready_r    <= cfg_wdata[0];
        default: begin
        end
      endcase
    end
  end

  // Effective buffer length, saturated to the supported range.
  always_comb begin
    if (buffer_length_r < LEN_MIN) begin
      len = LEN_MIN;
    end else if (buffer_length_r > DEPTH_CLAMP) begin
      len = DEPTH_CLAMP;
    end else begin
      len = buffer_length_r;
    end
  end

  assign active = (start_index_r < end_index_r) && buffer_ready_r && running_r;

  // One restoring division step: shift the remainder and try the divisor.
  assign rem_shift = {rem_r, 1'b0};
  assign trial     = {1'b0, rem_shift} - {2'b00, range_r};
  assign fit       = !trial[POS_W+1];

  // Sequencer next-state logic.
  always_comb begin
    state_nxt          = state_r;
    previous_gate_nxt  = previous_gate_r;
    running_nxt        = running_r;
    fresh_run_nxt      = fresh_run_r;
    write_position_nxt = write_position_r;
    progress_nxt       = progress_r;
    gate_nxt           = gate_r;
    sample_nxt         = sample_r;
    s_nxt              = s_r;
    e_nxt              = e_r;
    head_nxt           = head_r;
    rem_nxt            = rem_r;
    range_nxt          = range_r;
    quot_nxt           = quot_r;
    cnt_nxt            = cnt_r;
    we_nxt             = we_r;
    out_valid_nxt      = out_valid_r && !out_ready;
    out_we_nxt         = out_we_r;
    out_addr_nxt       = out_addr_r;
    out_data_nxt       = out_data_r;
    out_frac_nxt       = out_frac_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          gate_nxt   = in_gate;
          sample_nxt = in_sample_word;
          we_nxt     = 1'b0;
          state_nxt  = S_EDGE;
        end
      end

      // Gate edges, and the clamped record range.
      S_EDGE: begin
        if (gate_r && !previous_gate_r) begin
          running_nxt   = 1'b1;
          fresh_run_nxt = 1'b1;
        end else if (!gate_r && previous_gate_r) begin
          if (!continue_enable_r) begin
            write_position_nxt = '0;
          end
          running_nxt  = 1'b0;
          progress_nxt = '0;
        end
        previous_gate_nxt = gate_r;
        s_nxt     = (start_index_r >= len) ? (len - pos_t'(1)) : start_index_r;
        e_nxt     = (end_index_r >= len) ? len : end_index_r;
        state_nxt = S_FRESH;
      end

      // A new run moves the head to the start point unless continue mode is on.
      S_FRESH: begin
        if (active) begin
          if (fresh_run_r && !continue_enable_r) begin
            fresh_run_nxt      = 1'b0;
            write_position_nxt = s_r;
            progress_nxt       = '0;
          end
          state_nxt = S_HEAD;
        end else begin
          state_nxt = S_DONE;
        end
      end

      // End of range: wrap or stop. A head below start is raised to start.
      S_HEAD: begin
        if ((write_position_r >= e_r) && !loop_enable_r) begin
          running_nxt  = 1'b0;
          progress_nxt = FRAC_DONE;
          state_nxt    = S_DONE;
        end else begin
          if ((write_position_r >= e_r) || (write_position_r < s_r)) begin
            head_nxt = s_r;
          end else begin
            head_nxt = write_position_r;
          end
          we_nxt    = 1'b1;
          state_nxt = S_SUB;
        end
      end

      // Load the divider and advance the write position.
      S_SUB: begin
        rem_nxt            = head_r - s_r;
        range_nxt          = e_r - s_r;
        write_position_nxt = head_r + pos_t'(1);
        cnt_nxt            = '0;
        state_nxt          = S_DIV;
      end

      // One quotient bit per cycle.
      S_DIV: begin
        rem_nxt  = fit ? trial[POS_W-1:0] : rem_shift[POS_W-1:0];
        quot_nxt = {quot_r[QUOT_W-2:0], fit};
        cnt_nxt  = cnt_r + CNT_W'(1);
        if (cnt_r == CNT_LAST) begin
          progress_nxt = {1'b0, quot_r[QUOT_W-2:0], fit};
          state_nxt    = S_DONE;
        end
      end

      // Hand the result to the output register once it is free.
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_we_nxt    = we_r;
          out_addr_nxt  = we_r ? head_r[ADDR_W-1:0] : '0;
          out_data_nxt  = we_r ? sample_r : '0;
          out_frac_nxt  = progress_r;
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control and recorder state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r          <= S_IDLE;
      previous_gate_r  <= 1'b0;
      running_r        <= 1'b0;
      fresh_run_r      <= 1'b0;
      write_position_r <= '0;
      progress_r       <= '0;
      out_valid_r      <= 1'b0;
      we_r             <= 1'b0;
    end else begin
      state_r          <= state_nxt;
      previous_gate_r  <= previous_gate_nxt;
      running_r        <= running_nxt;
      fresh_run_r      <= fresh_run_nxt;
      write_position_r <= write_position_nxt;
      progress_r       <= progress_nxt;
      out_valid_r      <= out_valid_nxt;
      we_r             <= we_nxt;
    end
  end

  // Payload and working registers.
  always_ff @(posedge clk) begin
    gate_r     <= gate_nxt;
    sample_r   <= sample_nxt;
    s_r        <= s_nxt;
    e_r        <= e_nxt;
    head_r     <= head_nxt;
    rem_r      <= rem_nxt;
    range_r    <= range_nxt;
    quot_r     <= quot_nxt;
    cnt_r      <= cnt_nxt;
    out_we_r   <= out_we_nxt;
    out_addr_r <= out_addr_nxt;
    out_data_r <= out_data_nxt;
    out_frac_r <= out_frac_nxt;
  end

  assign in_ready          = (state_r == S_IDLE);
  assign out_valid         = out_valid_r;
  assign out_write_enable  = out_we_r;
  assign out_write_address = out_addr_r;
  assign out_write_data    = out_data_r;
  assign out_sync_fraction = out_frac_r;

  // A written sample always lies inside the range, so its fraction is below one.
  a_frac_below_one : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_we_r) |-> !out_frac_r[QUOT_W])
    else $error("fraction of a written sample reached one");

  // A result without a write carries a zero address and zero data.
  a_idle_payload_zero : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_we_r) |-> (out_addr_r == '0 && out_data_r == '0))
    else $error("non-write result carries address or data");

  // The divider remainder stays below the divisor.
  a_rem_below_range : assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV) |-> (rem_r < range_r))
    else $error("divider remainder not below divisor");

  // Division ends with the last quotient bit, moving on to S_DONE.
  a_div_exit : assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV && cnt_r == CNT_LAST) |=> (state_r == S_DONE))
    else $error("divider did not finish after the last quotient bit");

endmodule : gated_sample_recorder_core

`default_nettype wire

// ----- sim/gsr_checker.sv -----
// Checker for the gated sample recorder: tracks register writes, predicts each
// result transaction and compares it with what the block delivers.
// Depends on gsr_pkg for widths, reset values and register indexes.
`timescale 1ns / 1ps

module gsr_checker
  import gsr_pkg::*;
#(
  parameter int unsigned DEPTH = GSR_BUFFER_DEPTH
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_wr_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [POS_W-1:0]    cfg_wdata,
  input  logic                in_valid,
  input  logic                in_ready,
  input  logic                in_gate,
  input  logic [SAMPLE_W-1:0] in_sample_word,
  input  logic                out_valid,
  input  logic                out_ready,
  input  logic                out_write_enable,
  input  logic [ADDR_W-1:0]   out_write_address,
  input  logic [SAMPLE_W-1:0] out_write_data,
  input  logic [FRAC_W-1:0]   out_sync_fraction,
  output int unsigned         mismatch_count,
  output int unsigned         awaited_count
);

  // One extra bit so that lengths and ranges up to the full depth fit.
  typedef logic [POS_W:0] span_t;

  typedef struct packed {
    logic                wr_en;
    logic [ADDR_W-1:0]   wr_addr;
    logic [SAMPLE_W-1:0] wr_data;
    frac_t               frac;
  } buffer_write_t;

  localparam span_t MAX_LEN = span_t'(DEPTH);
  localparam span_t MIN_LEN = span_t'(2);

  // Shadow copy of the configuration registers.
  pos_t  start_pt;
  pos_t  end_pt;
  pos_t  buf_len;
  logic  loop_on;
  logic  keep_pos;
  logic  buf_ready;

  // Shadow copy of the recorder state.
  logic  gate_q;
  logic  recording;
  logic  run_pending;
  pos_t  head_pos;
  frac_t progress_q;

  buffer_write_t pending_writes[$];
  buffer_write_t oldest;
  int unsigned   fail_total = 0;

  // Advances the shadow state by one input transaction and returns the
  // buffer write and progress that it must produce.
  function automatic buffer_write_t record_sample(input logic gate,
                                                  input logic [SAMPLE_W-1:0] word);
    buffer_write_t res;
    span_t         eff_len;
    span_t         s_pt;
    span_t         e_pt;
    span_t         span;
    span_t         head;
    logic [37:0]   scaled;
    logic [37:0]   quot;
    res = '0;

    // Gate edges arm or stop a run.
    if (gate && !gate_q) begin
      recording   = 1'b1;
      run_pending = 1'b1;
    end else if (!gate && gate_q) begin
      if (!keep_pos) head_pos = '0;
      recording  = 1'b0;
      progress_q = '0;
    end
    gate_q = gate;

    if ((start_pt < end_pt) && buf_ready && recording) begin
      // Saturate the length and clamp the record range into the buffer.
      eff_len = span_t'(buf_len);
      if (eff_len < MIN_LEN) eff_len = MIN_LEN;
      if (eff_len > MAX_LEN) eff_len = MAX_LEN;
      s_pt = (span_t'(start_pt) >= eff_len) ? eff_len - span_t'(1) : span_t'(start_pt);
      e_pt = (span_t'(end_pt) >= eff_len) ? eff_len : span_t'(end_pt);
      span = e_pt - s_pt;

      if (run_pending && !keep_pos) begin
        run_pending = 1'b0;
        head_pos    = pos_t'(s_pt);
        progress_q  = '0;
      end

      head = span_t'(head_pos);
      if (head >= e_pt) begin
        if (loop_on) begin
          head = s_pt;
        end else begin
          recording  = 1'b0;
          progress_q = FRAC_DONE;
        end
      end
      if (head < s_pt) head = s_pt;

      if (recording) begin
        scaled = {16'b0, head - s_pt} << 16;
        quot   = scaled / {16'b0, span};
        progress_q  = (quot > 38'd65536) ? FRAC_DONE : quot[FRAC_W-1:0];
        res.wr_en   = 1'b1;
        res.wr_addr = head[ADDR_W-1:0];
        res.wr_data = word;
        head_pos    = pos_t'(head + span_t'(1));
      end
    end

    res.frac = progress_q;
    return res;
  endfunction

  // Register writes, prediction on input transactions and comparison on
  // output transactions, all sampled at the rising edge.
  always @(posedge clk) begin
    if (!rst_n) begin
      start_pt    = RST_START_INDEX;
      end_pt      = RST_END_INDEX;
      buf_len     = RST_BUFFER_LENGTH;
      loop_on     = 1'b0;
      keep_pos    = 1'b0;
      buf_ready   = 1'b1;
      gate_q      = 1'b0;
      recording   = 1'b0;
      run_pending = 1'b0;
      head_pos    = '0;
      progress_q  = '0;
      pending_writes.delete();
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          CFG_START_INDEX:     start_pt  = cfg_wdata;
          CFG_END_INDEX:       end_pt    = cfg_wdata;
          CFG_BUFFER_LENGTH:   buf_len   = cfg_wdata;
          CFG_LOOP_ENABLE:     loop_on   = cfg_wdata[0];
          CFG_CONTINUE_ENABLE: keep_pos  = cfg_wdata[0];
          CFG_BUFFER_READY:    buf_ready = cfg_wdata[0];
          default: ;
        endcase
      end

      if (in_valid && in_ready) begin
        pending_writes.push_back(record_sample(in_gate, in_sample_word));
      end

      if (out_valid && out_ready) begin
        if (pending_writes.size() == 0) begin
          $display("%0t: result transaction with nothing expected", $time);
          fail_total++;
        end else begin
          oldest = pending_writes.pop_front();
          if (out_write_enable !== oldest.wr_en) begin
            $display("%0t: write_enable expected %0d, got %0d",
                     $time, oldest.wr_en, out_write_enable);
            fail_total++;
          end
          if (out_write_address !== oldest.wr_addr) begin
            $display("%0t: write_address expected %h, got %h",
                     $time, oldest.wr_addr, out_write_address);
            fail_total++;
          end
          if (out_write_data !== oldest.wr_data) begin
            $display("%0t: write_data expected %h, got %h",
                     $time, oldest.wr_data, out_write_data);
            fail_total++;
          end
          if (out_sync_fraction !== oldest.frac) begin
            $display("%0t: sync_fraction expected %0d, got %0d",
                     $time, oldest.frac, out_sync_fraction);
            fail_total++;
          end
        end
      end
    end
    awaited_count  <= pending_writes.size();
    mismatch_count <= fail_total;
  end

endmodule : gsr_checker

// ----- sim/gated_sample_recorder_core_test.sv -----
// Top of the gated sample recorder testbench: clock, reset, register setup,
// input and output traffic, and the final verdict.
// Depends on gsr_pkg, gsr_checker and gated_sample_recorder_core.
`timescale 1ns / 1ps

module gated_sample_recorder_core_test;
  import gsr_pkg::*;

  localparam cfg_idx_t    CFG_SPARE_LO = 3'd6;
  localparam cfg_idx_t    CFG_SPARE_HI = 3'd7;
  localparam pos_t        POS_ALL_ONES = '1;
  localparam pos_t        TOP_ADDR     = pos_t'(GSR_BUFFER_DEPTH - 1);
  localparam int unsigned ITEM_TARGET  = 1320;
  localparam int unsigned STALL_LIMIT  = 4000;
  localparam int unsigned HOLD_CYCLES  = 400;
  localparam int unsigned HOLD_AT      = 300;

  logic                clk;
  logic                rst_n;
  logic                cfg_wr_en;
  cfg_idx_t            cfg_index;
  pos_t                cfg_wdata;
  logic                in_valid;
  logic                in_ready;
  logic                in_gate;
  logic [SAMPLE_W-1:0] in_sample_word;
  logic                out_valid;
  logic                out_ready;
  logic                out_write_enable;
  logic [ADDR_W-1:0]   out_write_address;
  logic [SAMPLE_W-1:0] out_write_data;
  logic [FRAC_W-1:0]   out_sync_fraction;

  int unsigned mismatches;
  int unsigned awaited;
  int unsigned items_sent;
  int unsigned quiet_cycles;
  int unsigned hold_left;
  logic        hold_done;
  logic        calm;
  int          phase_left;
  int          burst_len;

  // No random idling on either side during this stretch of the run.
  assign calm = (items_sent >= 600) && (items_sent < 900);

  gated_sample_recorder_core uut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_gate           (in_gate),
    .in_sample_word    (in_sample_word),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_write_enable  (out_write_enable),
    .out_write_address (out_write_address),
    .out_write_data    (out_write_data),
    .out_sync_fraction (out_sync_fraction)
  );

  gsr_checker check_unit (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_gate           (in_gate),
    .in_sample_word    (in_sample_word),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_write_enable  (out_write_enable),
    .out_write_address (out_write_address),
    .out_write_data    (out_write_data),
    .out_sync_fraction (out_sync_fraction),
    .mismatch_count    (mismatches),
    .awaited_count     (awaited)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Writes one register; the caller lowers the write enable after a batch.
  task automatic write_reg(input cfg_idx_t idx, input pos_t val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
  endtask

  task automatic load_settings(input pos_t st, input pos_t en, input pos_t ln,
                               input logic lp, input logic ct, input logic rd,
                               input logic stray);
    write_reg(CFG_START_INDEX, st);
    write_reg(CFG_END_INDEX, en);
    write_reg(CFG_BUFFER_LENGTH, ln);
    write_reg(CFG_LOOP_ENABLE, pos_t'(lp));
    write_reg(CFG_CONTINUE_ENABLE, pos_t'(ct));
    write_reg(CFG_BUFFER_READY, pos_t'(rd));
    // Writes to unused indexes must leave every register alone.
    if (stray) begin
      write_reg(CFG_SPARE_LO, pos_t'($urandom()));
      write_reg(CFG_SPARE_HI, pos_t'($urandom()));
    end
    cfg_wr_en <= 1'b0;
  endtask

  // Offers one input transaction, sometimes after a short idle gap.
  task automatic send_item(input logic g, input logic [SAMPLE_W-1:0] w);
    if (!calm && $urandom_range(0, 99) < 6) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_gate        <= g;
    in_sample_word <= w;
    do @(posedge clk); while (!in_ready);
    items_sent++;
  endtask

  task automatic run_gate(input logic g, input int unsigned n);
    repeat (n) send_item(g, $urandom());
  endtask

  // Waits until every predicted result has arrived, then lets the block settle.
  task automatic quiesce();
    in_valid <= 1'b0;
    @(posedge clk);
    while (awaited != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // Picks mostly short buffers and ranges so runs end and wrap often.
  task automatic random_settings();
    int unsigned pick;
    pos_t        ln;
    pos_t        st;
    pos_t        en;
    pick = $urandom_range(0, 99);
    if (pick < 75)      ln = pos_t'($urandom_range(2, 40));
    else if (pick < 82) ln = pos_t'($urandom_range(0, 1));
    else if (pick < 91) ln = RST_BUFFER_LENGTH;
    else                ln = pos_t'($urandom());

    if ($urandom_range(0, 9) == 0) st = pos_t'($urandom());
    else                           st = pos_t'($urandom_range(0, 32'(ln) + 32'd2));

    pick = $urandom_range(0, 99);
    if (pick < 65)      en = st + pos_t'($urandom_range(1, 12));
    else if (pick < 75) en = st - pos_t'($urandom_range(0, 3));
    else if (pick < 85) en = pos_t'($urandom_range(0, 32'(ln) + 32'd4));
    else if (pick < 93) en = pos_t'($urandom());
    else                en = RST_END_INDEX;

    load_settings(st, en, ln, 1'($urandom()), ($urandom_range(0, 3) == 0),
                  ($urandom_range(0, 9) != 0), ($urandom_range(0, 4) == 0));
  endtask

  // Stimulus: directed cases first, then random record runs.
  initial begin
    rst_n          <= 1'b0;
    cfg_wr_en      <= 1'b0;
    cfg_index      <= CFG_START_INDEX;
    cfg_wdata      <= '0;
    in_valid       <= 1'b0;
    in_gate        <= 1'b0;
    in_sample_word <= '0;
    items_sent     = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Settings after reset: idle item, run start, one more sample, stop.
    send_item(1'b0, 32'h0000_0000);
    send_item(1'b1, 32'hFFFF_FFFF);
    send_item(1'b1, 32'h0000_0000);
    send_item(1'b0, 32'hA5A5_A5A5);
    quiesce();

    // Run past the end point without looping.
    load_settings(pos_t'(2), pos_t'(5), pos_t'(8), 1'b0, 1'b0, 1'b1, 1'b0);
    run_gate(1'b1, 5);
    run_gate(1'b0, 1);
    quiesce();

    // Same range with wrap-around.
    load_settings(pos_t'(2), pos_t'(5), pos_t'(8), 1'b1, 1'b0, 1'b1, 1'b0);
    run_gate(1'b1, 5);
    run_gate(1'b0, 1);
    quiesce();

    // Too-short length, both points clamped, head raised to start, continue mode.
    load_settings(pos_t'(7), POS_ALL_ONES, pos_t'(1), 1'b0, 1'b1, 1'b1, 1'b1);
    run_gate(1'b1, 2);
    run_gate(1'b0, 1);
    quiesce();

    // Buffer not ready: nothing is written.
    load_settings(pos_t'(0), pos_t'(16), pos_t'(32), 1'b0, 1'b0, 1'b0, 1'b0);
    run_gate(1'b1, 1);
    run_gate(1'b0, 1);
    quiesce();

    // Oversized length saturates to the depth; last buffer address.
    load_settings(TOP_ADDR, RST_END_INDEX, POS_ALL_ONES, 1'b1, 1'b0, 1'b1, 1'b0);
    run_gate(1'b1, 2);
    run_gate(1'b0, 1);
    quiesce();

    // Random phases: mostly gate-high bursts with some gate noise.
    while (items_sent < ITEM_TARGET) begin
      random_settings();
      phase_left = $urandom_range(30, 70);
      while (phase_left > 0) begin
        burst_len = $urandom_range(1, 30);
        for (int k = 0; k < burst_len; k++) begin
          send_item(($urandom_range(0, 19) == 0) ? 1'($urandom()) : 1'b1, $urandom());
        end
        run_gate(1'b0, $urandom_range(1, 3));
        phase_left -= burst_len;
      end
      quiesce();
    end

    repeat (30) @(posedge clk);
    if (mismatches == 0 && awaited == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Result side: random stalls, plus one long hold-off that fills the block.
  initial begin
    out_ready <= 1'b0;
    hold_left = 0;
    hold_done = 1'b0;
    forever begin
      @(posedge clk);
      if (!hold_done && items_sent >= HOLD_AT) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 99) < 6) begin
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Watchdog: ends the run when no transaction moves for too long.
  initial begin
    quiet_cycles = 0;
    forever begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

endmodule : gated_sample_recorder_core_test
